FILE: hw/rtl/drgb_pkg.sv
// ----------------------------------------------------------------------------
// drgb_pkg
// Shared types and character codes for the decimal RGB triple parser.
// ----------------------------------------------------------------------------
package drgb_pkg;

  // Parse position within one line
  typedef enum logic [3:0] {
    PH_LEAD1  = 4'd0,
    PH_DIG1   = 4'd1,
    PH_TRAIL1 = 4'd2,
    PH_LEAD2  = 4'd3,
    PH_DIG2   = 4'd4,
    PH_TRAIL2 = 4'd5,
    PH_LEAD3  = 4'd6,
    PH_DIG3   = 4'd7,
    PH_DONE   = 4'd8
  } phase_e;

  // Line status reported with each result
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INCOMPL = 2'd1,
    ST_BADNUM  = 2'd2,
    ST_COMMA   = 2'd3
  } status_e;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [7:0] AlphaReset = 8'd100;
  localparam logic [7:0] ByteMax    = 8'd255;

endpackage

FILE: hw/rtl/decimal_rgb_triple_parser.sv
// ----------------------------------------------------------------------------
// decimal_rgb_triple_parser
// Parses an "R,G,B" text line, one ASCII character per word, into a packed
// colour word with a status.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one character per word in s_axis_tdata[7:0]; the
//   NUL character ends the line. Every non-NUL word only advances the parse
//   state and yields nothing. The NUL word yields one result word on the
//   master stream: bits 31:0 packed colour (alpha, red, green, blue from high
//   to low byte, zero on error), bits 33:32 status (ok, incomplete, bad
//   number, missing comma).
//   Throughput is one character per cycle while the result slot is free or
//   being emptied: the per-character step (classify, multiply the field
//   value by ten and add) sits between the parse state registers and the
//   result register. The result appears on the master side in the cycle
//   after the NUL word is taken.
//   When the receiver stalls with a result pending, the slave side drops
//   tready until the result is taken; a taking cycle frees the slot at once.
//   Reset clears the parse state, empties the result register and sets the
//   alpha byte to 100. The alpha byte is written via cfg_we_i / cfg_wdata_i.
// ----------------------------------------------------------------------------
module decimal_rgb_triple_parser
  import drgb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: alpha_value
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // input words: [7:0] char_code
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // result words: [31:0] packed_color, [33:32] parse_status, [39:34] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata
);

  logic [7:0]  alpha_q;
  phase_e      phase_q, phase_d;
  logic [7:0]  acc_q, acc_d;
  logic [7:0]  red_q, red_d;
  logic [7:0]  green_q, green_d;
  status_e     err_q, err_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_color_q, out_color_d;
  status_e     out_status_q, out_status_d;

  logic        accept;
  logic        is_nul, is_blank, is_digit, is_comma;
  logic [11:0] acc_next;
  status_e     line_status;

  // Take a word whenever the result slot is free or being emptied
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Classify the character
  assign is_nul   = (s_axis_tdata == CharNul);
  assign is_blank = (s_axis_tdata == CharSpace) || (s_axis_tdata == CharTab);
  assign is_digit = (s_axis_tdata >= CharZero) && (s_axis_tdata <= CharNine);
  assign is_comma = (s_axis_tdata == CharComma);

  // Field value times ten plus the new digit
  assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                  + {8'h00, s_axis_tdata[3:0]};

  // Status at line end
  always_comb begin
    line_status = err_q;
    if (err_q == ST_OK) begin
      unique case (phase_q)
        PH_LEAD1, PH_LEAD2, PH_LEAD3:             line_status = ST_INCOMPL;
        PH_DIG1, PH_DIG2, PH_TRAIL1, PH_TRAIL2:   line_status = ST_COMMA;
        default:                                  line_status = ST_OK;
      endcase
    end
  end

  // Parse step and result formation
  always_comb begin
    phase_d      = phase_q;
    acc_d        = acc_q;
    red_d        = red_q;
    green_d      = green_q;
    err_d        = err_q;
    out_color_d  = out_color_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && !m_axis_tready;

    if (accept) begin
      if (is_nul) begin
        // Emit the result and clear the line
        out_valid_d  = 1'b1;
        out_status_d = line_status;
        out_color_d  = (line_status == ST_OK) ?
                       {alpha_q, red_q, green_q, acc_q} : 32'h0;
        phase_d      = PH_LEAD1;
        acc_d        = '0;
        red_d        = '0;
        green_d      = '0;
        err_d        = ST_OK;
      end else if (err_q == ST_OK) begin
        unique case (phase_q)
          PH_LEAD1, PH_LEAD2, PH_LEAD3: begin
            if (is_digit) begin
              acc_d = {4'h0, s_axis_tdata[3:0]};
              unique case (phase_q)
                PH_LEAD1: phase_d = PH_DIG1;
                PH_LEAD2: phase_d = PH_DIG2;
                default:  phase_d = PH_DIG3;
              endcase
            end else if (!is_blank) begin
              err_d = ST_BADNUM;
            end
          end
          PH_DIG1, PH_DIG2: begin
            priority if (is_digit) begin
              if (acc_next > {4'h0, ByteMax}) err_d = ST_BADNUM;
              else                             acc_d = acc_next[7:0];
            end else if (is_blank) begin
              phase_d = (phase_q == PH_DIG1) ? PH_TRAIL1 : PH_TRAIL2;
            end else if (is_comma) begin
              acc_d = '0;
              if (phase_q == PH_DIG1) begin
                red_d   = acc_q;
                phase_d = PH_LEAD2;
              end else begin
                green_d = acc_q;
                phase_d = PH_LEAD3;
              end
            end else begin
              err_d = ST_COMMA;
            end
          end
          PH_TRAIL1, PH_TRAIL2: begin
            priority if (is_blank) begin
              phase_d = phase_q;
            end else if (is_comma) begin
              acc_d = '0;
              if (phase_q == PH_TRAIL1) begin
                red_d   = acc_q;
                phase_d = PH_LEAD2;
              end else begin
                green_d = acc_q;
                phase_d = PH_LEAD3;
              end
            end else begin
              err_d = ST_COMMA;
            end
          end
          PH_DIG3: begin
            if (is_digit) begin
              if (acc_next > {4'h0, ByteMax}) err_d = ST_BADNUM;
              else                             acc_d = acc_next[7:0];
            end else begin
              phase_d = PH_DONE;
            end
          end
          default: begin
            // Ignore the rest of the line
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  // Hold control state and the alpha byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q     <= AlphaReset;
      phase_q     <= PH_LEAD1;
      acc_q       <= '0;
      red_q       <= '0;
      green_q     <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) alpha_q <= cfg_wdata_i;
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      red_q       <= red_d;
      green_q     <= green_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_color_q  <= out_color_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, out_status_q, out_color_q};

  // A line end always leaves a result pending
  a_nul_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_nul |=> out_valid_q)
    else $error("no result after line end");

  // A line end returns the parse to its start
  a_nul_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_nul |=> (phase_q == PH_LEAD1) && (err_q == ST_OK) && (acc_q == 8'h00))
    else $error("parse state not cleared after line end");

  // A failed line reports a zero colour
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q != ST_OK) |-> (out_color_q == 32'h0))
    else $error("colour not zero on error status");

  // After an error, characters change nothing until the line end
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_nul && (err_q != ST_OK)
    |=> $stable(phase_q) && $stable(acc_q) && $stable(err_q))
    else $error("parse state moved after an error");

  // A new result is only loaded into a free slot
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !accept)
    else $error("word taken while result slot is full");

endmodule
